### design/dbf_pkg.sv
// ----------------------------------------------------------------------------
// dbf_pkg
// Shared constants and types of the digest Bloom filter.
// ----------------------------------------------------------------------------
package dbf_pkg;

    localparam int MAX_INDEX_BITS = 16;
    localparam int DIGEST_WORDS   = 5;
    localparam int MIN_INDEX_BITS = 4;

    localparam int WORD_BITS      = 32;
    localparam int INPUT_WORDS    = 5;
    localparam int DIGEST_BITS    = WORD_BITS * DIGEST_WORDS;
    localparam int REM_W          = $clog2(DIGEST_BITS + 1);

    // index_bits register and its shift arithmetic
    localparam int SIZE_W         = 5;
    localparam int RESET_SIZE     = 16;

    // bit store organized as rows of bits
    localparam int ROW_SEL_BITS   = (MAX_INDEX_BITS > 5) ? 5 : 1;
    localparam int ROW_BITS       = 2 ** ROW_SEL_BITS;
    localparam int ROW_ADDR_BITS  = MAX_INDEX_BITS - ROW_SEL_BITS;
    localparam int ROWS           = 2 ** ROW_ADDR_BITS;

    // configuration port
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = SIZE_W;
    localparam logic [CFG_INDEX_W-1:0] REG_INDEX_BITS    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STORE_ENABLED = 1'd1;

    // request codes
    localparam logic FUNC_CHECK = 1'b0;
    localparam logic FUNC_MARK  = 1'b1;

    typedef logic [MAX_INDEX_BITS-1:0] index_t;

    typedef struct packed {
        logic   valid;
        logic   mark;
        index_t idx;
    } dbf_req_t;

    typedef struct packed {
        logic clearing;
        logic busy;
        logic hit_valid;
        logic hit;
    } dbf_stat_t;

endpackage

### design/dbf_in_if.sv
// ----------------------------------------------------------------------------
// dbf_in_if
// Request channel: function code and 160-bit digest.
// ----------------------------------------------------------------------------
interface dbf_in_if
    import dbf_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [WORD_BITS-1:0] digest_word0;
    logic [WORD_BITS-1:0] digest_word1;
    logic [WORD_BITS-1:0] digest_word2;
    logic [WORD_BITS-1:0] digest_word3;
    logic [WORD_BITS-1:0] digest_word4;

    modport source (
        output valid, func, digest_word0, digest_word1, digest_word2,
               digest_word3, digest_word4,
        input  ready
    );

    modport sink (
        input  valid, func, digest_word0, digest_word1, digest_word2,
               digest_word3, digest_word4,
        output ready
    );
endinterface

### design/dbf_out_if.sv
// ----------------------------------------------------------------------------
// dbf_out_if
// Result channel: seen flag and function echo.
// ----------------------------------------------------------------------------
interface dbf_out_if;
    logic valid;
    logic ready;
    logic seen_before;
    logic op_done;

    modport source (
        output valid, seen_before, op_done,
        input  ready
    );

    modport sink (
        input  valid, seen_before, op_done,
        output ready
    );
endinterface

### design/dbf_index_gen.sv
// ----------------------------------------------------------------------------
// dbf_index_gen
// Walks the digest MSB first and issues one store index per cycle.
// ----------------------------------------------------------------------------
module dbf_index_gen
    import dbf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  logic                   load_mark,
    input  logic [SIZE_W-1:0]      load_size,
    input  logic [DIGEST_BITS-1:0] load_digest,
    output dbf_req_t               req
);

    logic [DIGEST_BITS-1:0]    sh_reg,   sh_next;
    logic [REM_W-1:0]          rem_reg,  rem_next;
    logic [SIZE_W-1:0]         size_reg, size_next;
    logic                      mark_reg, mark_next;
    logic                      active;
    logic [SIZE_W-1:0]         drop;
    logic [MAX_INDEX_BITS-1:0] top_bits;

    assign active   = rem_reg >= REM_W'(size_reg);
    assign drop     = SIZE_W'(MAX_INDEX_BITS) - size_reg;
    assign top_bits = sh_reg[DIGEST_BITS-1 -: MAX_INDEX_BITS];

    always_comb
    begin
        req.valid = active;
        req.mark  = mark_reg;
        req.idx   = top_bits >> drop;
    end

    always_comb
    begin
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        size_next = size_reg;
        mark_next = mark_reg;
        if (load)
        begin
            sh_next   = load_digest;
            rem_next  = REM_W'(DIGEST_BITS);
            size_next = load_size;
            mark_next = load_mark;
        end
        else if (active)
        begin
            sh_next  = sh_reg << size_reg;
            rem_next = rem_reg - REM_W'(size_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            size_reg <= SIZE_W'(RESET_SIZE);
            mark_reg <= FUNC_CHECK;
        end
        else
        begin
            rem_reg  <= rem_next;
            size_reg <= size_next;
            mark_reg <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

endmodule

### design/dbf_bit_store.sv
// ----------------------------------------------------------------------------
// dbf_bit_store
// Row-organized bit store: read, set bit, write back, with a one-deep
// forward of the last written row. Clears itself after reset.
// ----------------------------------------------------------------------------
module dbf_bit_store
    import dbf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  dbf_req_t  req,
    output dbf_stat_t stat
);

    logic [ROW_BITS-1:0] mem [ROWS];

    logic                     clearing_reg, clearing_next;
    logic [ROW_ADDR_BITS-1:0] clr_addr_reg, clr_addr_next;

    logic                     s1_valid_reg;
    logic                     s1_mark_reg;
    logic [ROW_ADDR_BITS-1:0] s1_row_reg;
    logic [ROW_SEL_BITS-1:0]  s1_sel_reg;
    logic [ROW_BITS-1:0]      rd_data_reg;

    logic                     wr_valid_reg;
    logic [ROW_ADDR_BITS-1:0] wr_row_reg;
    logic [ROW_BITS-1:0]      wr_data_reg;

    logic [ROW_BITS-1:0]      cur_row;
    logic [ROW_BITS-1:0]      set_row;
    logic                     do_mark;
    logic                     mem_we;
    logic [ROW_ADDR_BITS-1:0] mem_waddr;
    logic [ROW_BITS-1:0]      mem_wdata;

    // the row written last cycle is not yet visible in rd_data_reg
    assign cur_row = (wr_valid_reg && wr_row_reg == s1_row_reg) ? wr_data_reg : rd_data_reg;
    assign set_row = cur_row | (ROW_BITS'(1) << s1_sel_reg);
    assign do_mark = s1_valid_reg && s1_mark_reg;

    always_comb
    begin
        mem_we    = clearing_reg || do_mark;
        mem_waddr = clearing_reg ? clr_addr_reg : s1_row_reg;
        mem_wdata = clearing_reg ? '0 : set_row;
    end

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (&clr_addr_reg)
                clearing_next = 1'b0;
        end
    end

    always_comb
    begin
        stat.clearing  = clearing_reg;
        stat.busy      = s1_valid_reg;
        stat.hit_valid = s1_valid_reg && !s1_mark_reg;
        stat.hit       = cur_row[s1_sel_reg];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[req.idx[MAX_INDEX_BITS-1:ROW_SEL_BITS]];
    end

    always_ff @(posedge clk)
    begin
        s1_mark_reg <= req.mark;
        s1_row_reg  <= req.idx[MAX_INDEX_BITS-1:ROW_SEL_BITS];
        s1_sel_reg  <= req.idx[ROW_SEL_BITS-1:0];
        wr_row_reg  <= s1_row_reg;
        wr_data_reg <= set_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            s1_valid_reg <= req.valid;
            wr_valid_reg <= do_mark;
        end
    end

    a_no_req_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !req.valid)
        else $error("index request during clearing pass");

    a_mark_sets_bit: assert property (
        @(posedge clk) disable iff (!rst_n)
        do_mark |=> wr_valid_reg && wr_data_reg[$past(s1_sel_reg)])
        else $error("write-back row lacks the marked bit");

    a_check_no_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_mark_reg) |=> !wr_valid_reg)
        else $error("check request caused a write-back");

    a_forward_keeps_bits: assert property (
        @(posedge clk) disable iff (!rst_n)
        (do_mark && wr_valid_reg && wr_row_reg == s1_row_reg)
            |-> ((set_row & wr_data_reg) == wr_data_reg))
        else $error("forwarded row lost bits");

endmodule

### design/digest_bloom_filter_unit.sv
// ----------------------------------------------------------------------------
// digest_bloom_filter_unit
// Bloom filter keyed by a 160-bit digest; check and mark requests.
// ----------------------------------------------------------------------------
// A request passes from the idle state through the run state (enabled store)
// or straight to the done state (disabled store), and from there into the
// output register once it is free. While running, one bit-store row is read
// and, for a mark, written back per index. After reset the store runs a
// clearing pass over all 2048 rows (one 32-bit row per cycle) during which no
// request is taken; configuration writes are accepted throughout. A new
// request is taken while an earlier result still waits in the output
// register.
// ----------------------------------------------------------------------------
module digest_bloom_filter_unit
    import dbf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    dbf_in_if.sink                 item,
    dbf_out_if.source              result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [SIZE_W-1:0]   index_bits_reg, index_bits_next;
    logic                store_enabled_reg, store_enabled_next;
    logic                func_reg, func_next;
    logic                seen_reg, seen_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_seen_reg, out_seen_next;
    logic                out_func_reg, out_func_next;

    logic                   accept;
    logic                   load;
    logic                   out_free;
    logic [WORD_BITS-1:0]   words [INPUT_WORDS];
    logic [DIGEST_BITS-1:0] digest;
    dbf_req_t               req;
    dbf_stat_t              stat;

    assign words[0] = item.digest_word0;
    assign words[1] = item.digest_word1;
    assign words[2] = item.digest_word2;
    assign words[3] = item.digest_word3;
    assign words[4] = item.digest_word4;

    // big-endian bit string; words past the input read as zero
    always_comb
    begin
        for (int i = 0; i < DIGEST_BITS; i++)
        begin
            if (i / WORD_BITS < INPUT_WORDS)
                digest[DIGEST_BITS-1-i] = words[i / WORD_BITS][WORD_BITS-1-(i % WORD_BITS)];
            else
                digest[DIGEST_BITS-1-i] = 1'b0;
        end
    end

    assign item.ready = (state_reg == ST_IDLE) && !stat.clearing;
    assign accept     = item.valid && item.ready;
    assign load       = accept && store_enabled_reg;
    assign out_free   = !out_valid_reg || result.ready;

    assign result.valid       = out_valid_reg;
    assign result.seen_before = out_seen_reg;
    assign result.op_done     = out_func_reg;

    always_comb
    begin
        index_bits_next    = index_bits_reg;
        store_enabled_next = store_enabled_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_INDEX_BITS:
                begin
                    if (cfg_data >= SIZE_W'(MIN_INDEX_BITS) &&
                        cfg_data <= SIZE_W'(MAX_INDEX_BITS))
                        index_bits_next = cfg_data;
                end
                REG_STORE_ENABLED: store_enabled_next = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_seen_next  = out_seen_reg;
        out_func_next  = out_func_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next  = item.func;
                    // marks report zero; checks start from "all set" when the store is enabled, else zero
                    seen_next  = store_enabled_reg && (item.func == FUNC_CHECK);
                    state_next = store_enabled_reg ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN:
            begin
                if (stat.hit_valid)
                    seen_next = seen_reg && stat.hit;
                if (!req.valid && !stat.busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_seen_next  = seen_reg;
                    out_func_next  = func_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            index_bits_reg    <= SIZE_W'(RESET_SIZE);
            store_enabled_reg <= 1'b1;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            index_bits_reg    <= index_bits_next;
            store_enabled_reg <= store_enabled_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        seen_reg     <= seen_next;
        out_seen_reg <= out_seen_next;
        out_func_reg <= out_func_next;
    end

    dbf_index_gen u_index_gen (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .load_mark   (item.func),
        .load_size   (index_bits_reg),
        .load_digest (digest),
        .req         (req)
    );

    dbf_bit_store u_bit_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .stat  (stat)
    );

    a_idle_no_traffic: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !req.valid && !stat.busy)
        else $error("store traffic while idle");

    a_mark_reports_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && func_reg == FUNC_MARK) |-> !seen_reg)
        else $error("mark request would report seen");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the digest Bloom filter: a short table of directed
// requests and register writes, then randomized phases of check and mark
// traffic under varying index sizes and store enables, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import dbf_pkg::*;

    localparam int WATCHDOG_LIMIT = 10000;
    localparam int SETTLE_CYCLES  = 48;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 625;
    localparam int POOL_DEPTH     = 64;
    localparam int SIZE_FIELD_MAX = 2 ** CFG_DATA_W - 1;

    typedef logic [DIGEST_BITS-1:0] digest_t;

    typedef struct packed {
        logic seen_before;
        logic op_done;
    } answer_t;

    typedef enum logic {
        ROW_REQUEST,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] reg_sel;
        logic [CFG_DATA_W-1:0]  value;
        logic                   func;
        digest_t                digest;
        logic                   known;
        logic                   seen;
    } step_t;

    localparam digest_t DIG_ZERO = '0;
    localparam digest_t DIG_ONES = '1;
    localparam digest_t PAT_A = 160'h01234567_89abcdef_fedcba98_76543210_0f1e2d3c;
    localparam digest_t PAT_B = 160'h80000000_00000000_00000000_00000000_00000001;
    localparam digest_t PAT_C = 160'hdeadbeef_cafef00d_13579bdf_2468ace0_a5a55a5a;
    localparam digest_t PAT_D = 160'h55555555_aaaaaaaa_33333333_cccccccc_f0f0f0f0;
    localparam digest_t PAT_E = 160'h0000ffff_ffff0000_00ff00ff_ff00ff00_12345678;

    // kind, register, value, func, digest, answer known, seen_before
    localparam step_t DIRECTED [38] = '{
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_CHECK, DIG_ZERO, 1'b1, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_CHECK, DIG_ONES, 1'b1, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_MARK,  DIG_ZERO, 1'b1, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_CHECK, DIG_ZERO, 1'b1, 1'b1},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_CHECK, DIG_ONES, 1'b1, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_MARK,  DIG_ONES, 1'b1, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_CHECK, DIG_ONES, 1'b1, 1'b1},
        '{ROW_WRITE,   REG_INDEX_BITS,    5'd4,  FUNC_CHECK, DIG_ZERO, 1'b0, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_CHECK, PAT_A,    1'b0, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_MARK,  PAT_A,    1'b1, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_CHECK, DIG_ONES, 1'b0, 1'b0},
        // sizes out of range must leave index_bits at 4
        '{ROW_WRITE,   REG_INDEX_BITS,    5'd3,  FUNC_CHECK, DIG_ZERO, 1'b0, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_CHECK, PAT_B,    1'b0, 1'b0},
        '{ROW_WRITE,   REG_INDEX_BITS,    5'd17, FUNC_CHECK, DIG_ZERO, 1'b0, 1'b0},
        '{ROW_WRITE,   REG_INDEX_BITS,    5'd0,  FUNC_CHECK, DIG_ZERO, 1'b0, 1'b0},
        '{ROW_WRITE,   REG_INDEX_BITS,    5'd31, FUNC_CHECK, DIG_ZERO, 1'b0, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_MARK,  PAT_B,    1'b1, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_CHECK, PAT_C,    1'b0, 1'b0},
        // 7 does not divide 160: trailing digest bits go unused
        '{ROW_WRITE,   REG_INDEX_BITS,    5'd7,  FUNC_CHECK, DIG_ZERO, 1'b0, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_MARK,  PAT_C,    1'b1, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_CHECK, PAT_C,    1'b0, 1'b0},
        '{ROW_WRITE,   REG_INDEX_BITS,    5'd13, FUNC_CHECK, DIG_ZERO, 1'b0, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_CHECK, PAT_C,    1'b0, 1'b0},
        '{ROW_WRITE,   REG_STORE_ENABLED, 5'd0,  FUNC_CHECK, DIG_ZERO, 1'b0, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_CHECK, DIG_ONES, 1'b1, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_MARK,  PAT_D,    1'b1, 1'b0},
        // only bit 0 of the enable counts
        '{ROW_WRITE,   REG_STORE_ENABLED, 5'h1e, FUNC_CHECK, DIG_ZERO, 1'b0, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_CHECK, DIG_ZERO, 1'b1, 1'b0},
        '{ROW_WRITE,   REG_STORE_ENABLED, 5'd1,  FUNC_CHECK, DIG_ZERO, 1'b0, 1'b0},
        // mark issued while disabled must not have touched the store
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_CHECK, PAT_D,    1'b0, 1'b0},
        '{ROW_WRITE,   REG_INDEX_BITS,    5'd16, FUNC_CHECK, DIG_ZERO, 1'b0, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_CHECK, PAT_D,    1'b0, 1'b0},
        '{ROW_WRITE,   REG_INDEX_BITS,    5'd5,  FUNC_CHECK, DIG_ZERO, 1'b0, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_MARK,  PAT_E,    1'b1, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_CHECK, PAT_E,    1'b0, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_CHECK, PAT_B,    1'b0, 1'b0},
        '{ROW_WRITE,   REG_STORE_ENABLED, 5'h1f, FUNC_CHECK, DIG_ZERO, 1'b0, 1'b0},
        '{ROW_REQUEST, REG_INDEX_BITS,    5'd0,  FUNC_CHECK, PAT_E,    1'b0, 1'b0}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    dbf_in_if  req_if ();
    dbf_out_if res_if ();

    digest_bloom_filter_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (req_if),
        .result    (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // shadow of the filter
    bit      filter_bits [0:(2**MAX_INDEX_BITS)-1];
    int      index_size = RESET_SIZE;
    bit      store_on   = 1'b1;

    answer_t pending_answers [$];
    digest_t marked_pool [$];
    bit      failed;
    bit      hold_output;
    int      stall_cycles;
    answer_t due;

    function automatic answer_t bloom_answer(input logic f, input digest_t d);
        answer_t                   a;
        int                        count;
        logic [MAX_INDEX_BITS-1:0] idx;
        a.seen_before = 1'b0;
        a.op_done     = f;
        if (store_on)
        begin
            count = DIGEST_BITS / index_size;
            if (f == FUNC_CHECK)
                a.seen_before = 1'b1;
            for (int k = 0; k < count; k++)
            begin
                idx = '0;
                for (int b = 0; b < index_size; b++)
                    idx = {idx[MAX_INDEX_BITS-2:0], d[DIGEST_BITS-1-(k*index_size+b)]};
                if (f == FUNC_CHECK)
                begin
                    if (!filter_bits[idx])
                        a.seen_before = 1'b0;
                end
                else
                    filter_bits[idx] = 1'b1;
            end
        end
        return a;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(15, 60);
    endfunction

    function automatic digest_t random_digest();
        return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] sel,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (sel == REG_INDEX_BITS)
        begin
            if (int'(value) >= MIN_INDEX_BITS && int'(value) <= MAX_INDEX_BITS)
                index_size = int'(value);
        end
        else if (sel == REG_STORE_ENABLED)
            store_on = value[0];
    endtask

    task automatic offer_request(input logic f, input digest_t d, input logic known,
                                 input logic seen, input int gap);
        answer_t a;
        req_if.valid        <= 1'b1;
        req_if.func         <= f;
        req_if.digest_word0 <= d[4*WORD_BITS +: WORD_BITS];
        req_if.digest_word1 <= d[3*WORD_BITS +: WORD_BITS];
        req_if.digest_word2 <= d[2*WORD_BITS +: WORD_BITS];
        req_if.digest_word3 <= d[1*WORD_BITS +: WORD_BITS];
        req_if.digest_word4 <= d[0 +: WORD_BITS];
        do
            @(posedge clk);
        while (!req_if.ready);
        a = bloom_answer(f, d);
        if (known)
            a.seen_before = seen;
        pending_answers.push_back(a);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // block must be idle before any register write
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got seen_before %0b op_done %0b",
                         $time, res_if.seen_before, res_if.op_done);
                failed = 1'b1;
            end
            else
            begin
                due = pending_answers.pop_front();
                if (res_if.seen_before !== due.seen_before)
                begin
                    $display("%0t: seen_before mismatch, expected %0b, got %0b",
                             $time, due.seen_before, res_if.seen_before);
                    failed = 1'b1;
                end
                if (res_if.op_done !== due.op_done)
                begin
                    $display("%0t: op_done mismatch, expected %0b, got %0b",
                             $time, due.op_done, res_if.op_done);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side back-pressure
    initial
    begin
        int mode;
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 99);
            if (hold_output)
            begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            else if (mode < 8)
            begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(100, 300)) @(posedge clk);
            end
            else if (mode < 55)
            begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
            else if (mode < 92)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(10, 60)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int      phase;
        int      phase_len;
        int      sent;
        int      r;
        int      flip;
        bit      gapless;
        logic    f;
        digest_t d;
        logic [CFG_DATA_W-1:0] size_val;

        foreach (filter_bits[i])
            filter_bits[i] = 1'b0;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= REG_INDEX_BITS;
        cfg_data            <= '0;
        req_if.valid        <= 1'b0;
        req_if.func         <= FUNC_CHECK;
        req_if.digest_word0 <= '0;
        req_if.digest_word1 <= '0;
        req_if.digest_word2 <= '0;
        req_if.digest_word3 <= '0;
        req_if.digest_word4 <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(DIRECTED[i].reg_sel, DIRECTED[i].value);
            end
            else
                offer_request(DIRECTED[i].func, DIRECTED[i].digest, DIRECTED[i].known,
                              DIRECTED[i].seen, pick_gap());
        end

        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            r = $urandom_range(0, 99);
            if (r < 20)
                size_val = CFG_DATA_W'(MIN_INDEX_BITS);
            else if (r < 40)
                size_val = CFG_DATA_W'(MAX_INDEX_BITS);
            else if (r < 85)
                size_val = CFG_DATA_W'($urandom_range(MIN_INDEX_BITS, MAX_INDEX_BITS));
            else if (r < 92)
                size_val = CFG_DATA_W'($urandom_range(0, MIN_INDEX_BITS - 1));
            else
                size_val = CFG_DATA_W'($urandom_range(MAX_INDEX_BITS + 1, SIZE_FIELD_MAX));
            write_reg(REG_INDEX_BITS, size_val);
            size_val = CFG_DATA_W'($urandom());
            size_val[0] = ($urandom_range(0, 99) < 85);
            write_reg(REG_STORE_ENABLED, size_val);

            phase_len = $urandom_range(30, 70);
            gapless   = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++)
            begin
                // one long receiver hold-off while requests keep coming
                if (phase == 2 && n == 8)
                    hold_output = 1'b1;
                r = $urandom_range(0, 99);
                if (r < 35)
                begin
                    f = FUNC_MARK;
                    if (marked_pool.size() != 0 && $urandom_range(0, 2) == 0)
                        d = marked_pool[$urandom_range(0, marked_pool.size() - 1)];
                    else
                        d = random_digest();
                    marked_pool.push_back(d);
                    if (marked_pool.size() > POOL_DEPTH)
                        void'(marked_pool.pop_front());
                end
                else
                begin
                    f = FUNC_CHECK;
                    if (r < 78 && marked_pool.size() != 0)
                    begin
                        d = marked_pool[$urandom_range(0, marked_pool.size() - 1)];
                        if (r >= 65)
                        begin
                            flip = $urandom_range(0, DIGEST_BITS - 1);
                            d[flip] = ~d[flip];
                        end
                    end
                    else
                        d = random_digest();
                end
                offer_request(f, d, 1'b0, 1'b0, gapless ? 0 : pick_gap());
                sent++;
            end
            phase++;
        end

        wait_idle();
        if (!failed)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
design/dbf_pkg.sv
design/dbf_in_if.sv
design/dbf_out_if.sv
design/dbf_index_gen.sv
design/dbf_bit_store.sv
design/digest_bloom_filter_unit.sv
sim/testbench.sv
